@@ src/bfs_pkg.sv @@
// Shared constants, codes and controller/datapath command types for the BFS engine.
package bfs_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_DEGREE   = 16;

  localparam int VW   = 4;                          // vertex field width
  localparam int CW   = $clog2(MAX_VERTICES + 1);   // vertex count / queue pointer
  localparam int QIW  = $clog2(MAX_VERTICES);       // queue index
  localparam int DGW  = $clog2(MAX_DEGREE + 1);     // degree value
  localparam int DIW  = $clog2(MAX_DEGREE);         // slot index within a vertex
  localparam int NAW  = QIW + DIW;                  // neighbour store address
  localparam int NDEP = MAX_VERTICES * MAX_DEGREE;

  localparam logic [1:0] OP_CLEAR      = 2'd0;
  localparam logic [1:0] OP_ADD_VERTEX = 2'd1;
  localparam logic [1:0] OP_ADD_EDGE   = 2'd2;
  localparam logic [1:0] OP_TRAVERSE   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LIMIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic pop;     // dequeue next vertex and load its degree
    logic scan;    // step to next older neighbour, issue store read
    logic take;    // emit pending vertex, make fetched neighbour pending
    logic fin;     // emit pending vertex with last set
  } bfs_cmd_t;

  typedef struct packed {
    logic trav_ok;   // accepted item is a traversal from a known vertex
    logic q_empty;
    logic d_zero;
    logic w_new;     // fetched neighbour is unvisited and queue has room
    logic out_free;  // output register can load this cycle
  } bfs_stat_t;

endpackage

@@ src/bfs_in_if.sv @@
// Input channel interface: command transactions into the BFS engine.
interface bfs_in_if import bfs_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [1:0]    opcode;
  logic [VW-1:0] from_vertex;
  logic [VW-1:0] vertex;

  modport source (output valid, output opcode, output from_vertex, output vertex,
                  input ready);
  modport sink   (input valid, input opcode, input from_vertex, input vertex,
                  output ready);
endinterface

@@ src/bfs_out_if.sv @@
// Result channel interface: visited vertices and status out of the BFS engine.
interface bfs_out_if import bfs_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [VW-1:0] visited_vertex;
  logic          last;
  logic [1:0]    status;

  modport source (output valid, output visited_vertex, output last, output status,
                  input ready);
  modport sink   (input valid, input visited_vertex, input last, input status,
                  output ready);
endinterface

@@ src/bfs_ctrl.sv @@
// Controller state machine sequencing graph updates and the breadth-first walk.
module bfs_ctrl import bfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bfs_stat_t stat,
  output bfs_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && stat.out_free;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid && in_ready;
        if (cmd.accept && stat.trav_ok) state_nxt = S_POP;
      end
      S_POP: begin
        if (stat.q_empty) begin
          state_nxt = S_FIN;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.d_zero) begin
          state_nxt = S_POP;
        end else begin
          cmd.scan  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // hold while a new vertex waits for the output register
        if (!stat.w_new) begin
          state_nxt = S_SCAN;
        end else if (stat.out_free) begin
          cmd.take  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

@@ src/bfs_dpath.sv @@
// Datapath: graph storage, visited marks, work queue, pending vertex and output register.
module bfs_dpath import bfs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  bfs_cmd_t        cmd,
  output bfs_stat_t       stat,
  input  logic [1:0]      in_opcode,
  input  logic [VW-1:0]   in_from_vertex,
  input  logic [VW-1:0]   in_vertex,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [VW-1:0]   out_visited_vertex,
  output logic            out_last,
  output logic [1:0]      out_status
);

  logic [CW-1:0]           vcount_r;
  logic [DGW-1:0]          degree_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited_r;
  logic [VW-1:0]           queue_r [MAX_VERTICES];
  logic [CW-1:0]           head_r, tail_r;
  logic [VW-1:0]           cur_r;
  logic [DGW-1:0]          d_r;
  logic [VW-1:0]           pend_r;
  logic [VW-1:0]           nbr_mem [NDEP];
  logic [VW-1:0]           nbr_q_r;

  logic                    out_valid_r;
  logic [VW-1:0]           out_vtx_r;
  logic                    out_last_r;
  logic [1:0]              out_status_r;

  logic [VW-1:0]           deg_sel;
  logic [DGW-1:0]          deg_rd;
  logic [DGW-1:0]          d_dec;
  logic                    u_known, v_known, edge_full, edge_ok;
  logic                    out_load;
  logic [VW-1:0]           out_vtx_nxt;
  logic                    out_last_nxt;
  logic [1:0]              out_status_nxt;

  // one read port on the degree array: dequeued vertex while walking, edge source otherwise
  assign deg_sel   = cmd.pop ? queue_r[head_r[QIW-1:0]] : in_from_vertex;
  assign deg_rd    = degree_r[deg_sel];
  assign d_dec     = d_r - DGW'(1);

  assign u_known   = {1'b0, in_from_vertex} < vcount_r;
  assign v_known   = {1'b0, in_vertex} < vcount_r;
  assign edge_full = deg_rd >= DGW'(MAX_DEGREE);
  assign edge_ok   = u_known && v_known && !edge_full;

  assign stat.trav_ok  = (in_opcode == OP_TRAVERSE) && v_known;
  assign stat.q_empty  = head_r == tail_r;
  assign stat.d_zero   = d_r == '0;
  assign stat.w_new    = !visited_r[nbr_q_r] && (tail_r < CW'(MAX_VERTICES));
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_load       = 1'b0;
    out_vtx_nxt    = '0;
    out_last_nxt   = 1'b1;
    out_status_nxt = ST_OK;
    if (cmd.accept) begin
      out_load = 1'b1;
      case (in_opcode)
        OP_CLEAR:      out_status_nxt = ST_OK;
        OP_ADD_VERTEX: out_status_nxt = (vcount_r >= CW'(MAX_VERTICES)) ? ST_LIMIT : ST_OK;
        OP_ADD_EDGE: begin
          if (!(u_known && v_known)) out_status_nxt = ST_UNKNOWN;
          else if (edge_full)        out_status_nxt = ST_FULL;
          else                       out_status_nxt = ST_OK;
        end
        OP_TRAVERSE: begin
          // a good start vertex stays pending until the walk says whether it is last
          out_load       = !v_known;
          out_status_nxt = ST_UNKNOWN;
        end
        default: out_status_nxt = ST_OK;
      endcase
    end else if (cmd.take || cmd.fin) begin
      out_load     = 1'b1;
      out_vtx_nxt  = pend_r;
      out_last_nxt = cmd.fin;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= '0;
      visited_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) degree_r[i] <= '0;
    end else begin
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cmd.accept) begin
        case (in_opcode)
          OP_CLEAR: begin
            vcount_r  <= '0;
            visited_r <= '0;
            for (int i = 0; i < MAX_VERTICES; i++) degree_r[i] <= '0;
          end
          OP_ADD_VERTEX: begin
            if (vcount_r < CW'(MAX_VERTICES)) vcount_r <= vcount_r + CW'(1);
          end
          OP_ADD_EDGE: begin
            if (edge_ok) degree_r[in_from_vertex] <= deg_rd + DGW'(1);
          end
          OP_TRAVERSE: begin
            if (v_known) begin
              // clear all marks and set only the start vertex
              visited_r <= MAX_VERTICES'(1) << in_vertex;
              head_r    <= '0;
              tail_r    <= CW'(1);
            end
          end
          default: ;
        endcase
      end

      if (cmd.pop) head_r <= head_r + CW'(1);

      if (cmd.take) begin
        visited_r[nbr_q_r] <= 1'b1;
        tail_r             <= tail_r + CW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vtx_r    <= out_vtx_nxt;
      out_last_r   <= out_last_nxt;
      out_status_r <= out_status_nxt;
    end
    if (cmd.accept && in_opcode == OP_TRAVERSE) begin
      queue_r[0] <= in_vertex;
      pend_r     <= in_vertex;
    end
    if (cmd.pop) begin
      cur_r <= deg_sel;
      d_r   <= deg_rd;
    end
    if (cmd.scan) d_r <= d_dec;
    if (cmd.take) begin
      queue_r[tail_r[QIW-1:0]] <= nbr_q_r;
      pend_r                   <= nbr_q_r;
    end
  end

  // neighbour store: write on edge add, registered read while scanning newest-first
  always_ff @(posedge clk) begin
    if (cmd.accept && in_opcode == OP_ADD_EDGE && edge_ok)
      nbr_mem[{in_from_vertex, deg_rd[DIW-1:0]}] <= in_vertex;
    if (cmd.scan)
      nbr_q_r <= nbr_mem[{cur_r, d_dec[DIW-1:0]}];
  end

  assign out_valid          = out_valid_r;
  assign out_visited_vertex = out_vtx_r;
  assign out_last           = out_last_r;
  assign out_status         = out_status_r;

endmodule

@@ src/bfs_graph_traversal.sv @@
// Breadth-first traversal engine: top level joining controller and datapath.
// Clear, add-vertex and add-edge results are valid the cycle after
// the transaction, and a new item is taken every cycle the output can move.
// A traversal dequeues each reached vertex in S_POP, scans its edges in S_SCAN and S_CHECK
// and ends in S_FIN on an empty queue; output stalls can hold it, and no item is taken meanwhile.
// Reset clears vertex count, degrees, visited marks and queue pointers, not the edge store.
module bfs_graph_traversal import bfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bfs_in_if.sink    in_ch,
  bfs_out_if.source out_ch
);

  bfs_cmd_t  cmd;
  bfs_stat_t stat;

  bfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfs_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_ch.opcode),
    .in_from_vertex     (in_ch.from_vertex),
    .in_vertex          (in_ch.vertex),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_visited_vertex (out_ch.visited_vertex),
    .out_last           (out_ch.last),
    .out_status         (out_ch.status)
  );

endmodule
